// ===== rtl/sti_pkg.sv =====
// ---------------------------------------------------------------------------
// sti_pkg: shared types for the sorted table insert core
// Holds field widths, the result status codes, the sequencer states and the
// control bundle that the top level sends down the row of table cells.
// ---------------------------------------------------------------------------
package sti_pkg;

	localparam int KEY_W     = 31;
	localparam int PAYLOAD_W = 32;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_DUPLICATE = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_UPDATE
	} state_t;

	typedef struct packed {
		logic cmp;   // compare the incoming key against every held entry
		logic ins;   // commit the insert: hold, load or shift up
	} cell_ctrl_t;

endpackage

// ===== rtl/sti_cell.sv =====
// ---------------------------------------------------------------------------
// sti_cell: one table slot
// Holds one key and payload with a valid bit, compares the held key against
// the request key, and on insert either holds, takes the new entry, or takes
// the entry of its lower neighbor.
// ---------------------------------------------------------------------------
module sti_cell
	import sti_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_ctrl_t           ctrl,
	input  logic [KEY_W-1:0]     cmp_key,
	input  logic [KEY_W-1:0]     new_key,
	input  logic [PAYLOAD_W-1:0] new_payload,
	input  logic [KEY_W-1:0]     prev_key,
	input  logic [PAYLOAD_W-1:0] prev_payload,
	input  logic                 prev_valid,
	input  logic                 prev_lt,
	output logic [KEY_W-1:0]     key_q,
	output logic [PAYLOAD_W-1:0] payload_q,
	output logic                 valid_q,
	output logic                 lt_q,
	output logic                 eq_q,
	output logic                 hit
);

	// first slot whose key is not below the request key
	assign hit = prev_lt && !lt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			lt_q    <= 1'b0;
			eq_q    <= 1'b0;
		end else begin
			if (ctrl.cmp) begin
				lt_q <= valid_q && (key_q < cmp_key);
				eq_q <= valid_q && (key_q == cmp_key);
			end
			if (ctrl.ins && !lt_q) begin
				valid_q <= hit ? 1'b1 : prev_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins && !lt_q) begin
			key_q     <= hit ? new_key : prev_key;
			payload_q <= hit ? new_payload : prev_payload;
		end
	end

endmodule

// ===== rtl/sorted_table_insert_unique_core.sv =====
// ---------------------------------------------------------------------------
// sorted_table_insert_unique_core: sorted key table with unique insert
// Keeps up to DEPTH key/payload entries in ascending key order in a row of
// cells and inserts new keys in place, refusing duplicates and overflow.
// ---------------------------------------------------------------------------
// Usage:
//   Request: drive key and payload with start high; the request is taken at
//   a rising edge where start is high and busy is low.
//   Every cell compares its key with the request key at that same edge.
//   In the next cycle the sequencer commits: cells above the insert point
//   take their lower neighbor's entry, the slot at the insert point loads
//   the new entry, and cells below hold.
//   Result: done is high for exactly one cycle, the cycle after the commit,
//   with status, position and count valid in that cycle only.
//   Sequence: the accepting edge enters S_UPDATE; the edge that leaves
//   S_UPDATE commits the insert and raises done.
//   A new request is not taken while the cell row commits the previous one;
//   busy is high during that commit, the shift cycle (S_UPDATE).
//   A new request may be taken in the cycle done is high.
//   Reset: arst_n clears the count and all valid bits; the table is empty.
//   The receiver cannot stall: a result not taken in its done cycle is lost.
// ---------------------------------------------------------------------------
module sorted_table_insert_unique_core
	import sti_pkg::*;
#(
	parameter int DEPTH = 64,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [KEY_W-1:0]     key,
	input  logic [PAYLOAD_W-1:0] payload,
	output logic                 done,
	output logic [1:0]           status,
	output logic [PW-1:0]        position,
	output logic [CW-1:0]        count
);

	state_t state_q, state_next;
	cell_ctrl_t ctrl;

	logic [KEY_W-1:0]     req_key_q;
	logic [PAYLOAD_W-1:0] req_payload_q;
	logic [CW-1:0]        count_q;
	logic                 done_q;
	status_t              status_q;
	logic [PW-1:0]        position_q;

	logic [KEY_W-1:0]     cell_key   [DEPTH];
	logic [PAYLOAD_W-1:0] cell_payload [DEPTH];
	logic [DEPTH-1:0]     cell_valid;
	logic [DEPTH-1:0]     cell_lt;
	logic [DEPTH-1:0]     cell_eq;
	logic [DEPTH-1:0]     cell_hit;

	logic                 dup;
	logic                 full;
	logic [PW-1:0]        hit_pos;
	logic                 accept;

	assign accept = start && !busy;
	assign dup    = |cell_eq;
	assign full   = (count_q == CW'(DEPTH));

	// cells form a prefix of lt bits, so exactly one hit at most
	always_comb begin
		hit_pos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (cell_hit[i]) begin
				hit_pos = hit_pos | PW'(i);
			end
		end
	end

	always_comb begin
		state_next = state_q;
		busy       = 1'b0;
		ctrl.cmp   = 1'b0;
		ctrl.ins   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				ctrl.cmp = start;
				if (start) begin
					state_next = S_UPDATE;
				end
			end
			S_UPDATE: begin
				busy       = 1'b1;
				ctrl.ins   = !dup && !full;
				state_next = S_IDLE;
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_next;
			done_q  <= (state_q == S_UPDATE);
			if (ctrl.ins) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_key_q     <= key;
			req_payload_q <= payload;
		end
		if (state_q == S_UPDATE) begin
			priority if (dup) begin
				status_q   <= ST_DUPLICATE;
				position_q <= hit_pos;
			end else if (full) begin
				status_q   <= ST_FULL;
				position_q <= '0;
			end else begin
				status_q   <= ST_INSERTED;
				position_q <= hit_pos;
			end
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_first
			sti_cell u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.ctrl         (ctrl),
				.cmp_key      (key),
				.new_key      (req_key_q),
				.new_payload  (req_payload_q),
				.prev_key     (req_key_q),
				.prev_payload (req_payload_q),
				.prev_valid   (1'b1),
				.prev_lt      (1'b1),
				.key_q        (cell_key[g]),
				.payload_q    (cell_payload[g]),
				.valid_q      (cell_valid[g]),
				.lt_q         (cell_lt[g]),
				.eq_q         (cell_eq[g]),
				.hit          (cell_hit[g])
			);
		end else begin : g_rest
			sti_cell u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.ctrl         (ctrl),
				.cmp_key      (key),
				.new_key      (req_key_q),
				.new_payload  (req_payload_q),
				.prev_key     (cell_key[g-1]),
				.prev_payload (cell_payload[g-1]),
				.prev_valid   (cell_valid[g-1]),
				.prev_lt      (cell_lt[g-1]),
				.key_q        (cell_key[g]),
				.payload_q    (cell_payload[g]),
				.valid_q      (cell_valid[g]),
				.lt_q         (cell_lt[g]),
				.eq_q         (cell_eq[g]),
				.hit          (cell_hit[g])
			);
		end
	end

	assign done     = done_q;
	assign status   = status_q;
	assign position = position_q;
	assign count    = count_q;

endmodule
